// File: design/yfc_pkg.sv
// ----------------------------------------------------------------------------
// yfc_pkg
// Shared codes for the YUV 4:2:0 frame to ARGB converter: operations, status,
// layout codes and configuration register indexes.
// ----------------------------------------------------------------------------
package yfc_pkg;

  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_APPEND  = 2'd1;
  localparam logic [1:0] OP_CONVERT = 2'd2;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_UNSUP   = 2'd1;
  localparam logic [1:0] STAT_SHORT   = 2'd2;
  localparam logic [1:0] STAT_OUTSIDE = 2'd3;

  localparam logic [5:0] FMT_PLANAR_A = 6'd19;
  localparam logic [5:0] FMT_PLANAR_B = 6'd20;
  localparam logic [5:0] FMT_SEMI_A   = 6'd21;
  localparam logic [5:0] FMT_SEMI_B   = 6'd39;

  localparam logic [2:0] CFG_COLOR_FORMAT = 3'd0;
  localparam logic [2:0] CFG_OUTPUT_ABGR  = 3'd1;
  localparam logic [2:0] CFG_FRAME_WIDTH  = 3'd2;
  localparam logic [2:0] CFG_FRAME_HEIGHT = 3'd3;
  localparam logic [2:0] CFG_LUMA_STRIDE  = 3'd4;
  localparam logic [2:0] CFG_SLICE_HEIGHT = 3'd5;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

endpackage

// File: design/yfc_payload_ram.sv
// ----------------------------------------------------------------------------
// yfc_payload_ram
// Single-port byte store for the frame payload. Registered read data; an
// address at or past the end reads as zero.
// ----------------------------------------------------------------------------
module yfc_payload_ram #(
  parameter int DEPTH = 4194304,
  parameter int AW    = 22,
  parameter int LW    = 23
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [LW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;
  logic       oob_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr[AW-1:0]] <= wdata;
      end else begin
        rdata_r <= mem[addr[AW-1:0]];
        oob_r   <= (addr >= LW'(DEPTH));
      end
    end
  end

  assign rdata = oob_r ? 8'd0 : rdata_r;

endmodule

// File: design/yfc_divider.sv
// ----------------------------------------------------------------------------
// yfc_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module yfc_divider #(
  parameter int NW = 24,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [NW-1:0] quotient_o
);

  localparam int CW = $clog2(NW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] rem_r;
  logic [NW-1:0] quo_r;
  logic [DW-1:0] dsr_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;

  assign trial = {rem_r, quo_r[NW-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign fits  = (trial >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      rem_r <= '0;
      quo_r <= dividend_i;
      dsr_r <= divisor_i;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DW-1:0] : trial[DW-1:0];
      quo_r <= {quo_r[NW-2:0], fits};
    end
  end

  assign done_o     = done_r;
  assign quotient_o = quo_r;

endmodule

// File: design/yfc_colour.sv
// ----------------------------------------------------------------------------
// yfc_colour
// BT.601 integer YUV to RGB transform with luma floor and channel clamps.
// Products registered, then sums, clamps and packing registered.
// ----------------------------------------------------------------------------
module yfc_colour
  import yfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        valid_i,
  input  logic        abgr_i,
  input  logic [7:0]  y_i,
  input  logic [7:0]  u_i,
  input  logic [7:0]  v_i,
  output logic        valid_o,
  output logic [31:0] word_o
);

  logic signed [19:0] c_s, d_s, e_s;
  logic [7:0]         c_u;
  logic [8:0]         d9, e9;
  logic               v1_r, v2_r;
  logic signed [19:0] pc_r, pre_r, pgd_r, pge_r, pbd_r;
  logic signed [19:0] sr, sg, sb;
  logic [7:0]         r8, g8, b8;
  logic [31:0]        word_r;

  function automatic logic [7:0] clamp8(input logic signed [19:0] s);
    logic signed [19:0] q;
    q = s >>> 8;
    if (s < 0) return 8'd0;
    if (q > 20'sd255) return 8'd255;
    return q[7:0];
  endfunction

  assign c_u = (y_i < 8'd16) ? 8'd0 : (y_i - 8'd16);
  assign d9  = {1'b0, u_i} - 9'd128;
  assign e9  = {1'b0, v_i} - 9'd128;
  assign c_s = {12'd0, c_u};
  assign d_s = {{11{d9[8]}}, d9};
  assign e_s = {{11{e9[8]}}, e9};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= valid_i;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    pc_r  <= c_s * 20'sd298;
    pre_r <= e_s * 20'sd409;
    pgd_r <= d_s * 20'sd100;
    pge_r <= e_s * 20'sd208;
    pbd_r <= d_s * 20'sd516;
  end

  assign sr = pc_r + pre_r + 20'sd128;
  assign sg = pc_r - pgd_r - pge_r + 20'sd128;
  assign sb = pc_r + pbd_r + 20'sd128;
  assign r8 = clamp8(sr);
  assign g8 = clamp8(sg);
  assign b8 = clamp8(sb);

  always_ff @(posedge clk) begin
    word_r <= abgr_i ? {ALPHA_OPAQUE, b8, g8, r8} : {ALPHA_OPAQUE, r8, g8, b8};
  end

  assign valid_o = v2_r;
  assign word_o  = word_r;

endmodule

// File: design/yuv420_frame_to_argb_converter_unit.sv
// ----------------------------------------------------------------------------
// yuv420_frame_to_argb_converter_unit
// Clear and append transactions may follow every cycle while busy is low.
// A convert transaction holds busy until its result is strobed as busy falls;
// the serial quotient for the luma row count and three reads of the
// single-port payload memory set how long busy lasts. Error results come
// sooner, from the check state, before the payload reads. Results cannot be
// stalled. Synchronous reset clears the length and control and sets the
// configuration registers to their defaults; the payload memory is not cleared.
// ----------------------------------------------------------------------------
module yuv420_frame_to_argb_converter_unit
  import yfc_pkg::*;
#(
  parameter int PAYLOAD_BYTES = 4194304,
  parameter int MAX_DIMENSION = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_payload_byte,
  input  logic [11:0] in_pixel_column,
  input  logic [11:0] in_pixel_row,
  output logic        out_valid,
  output logic [31:0] out_pixel_word,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [13:0] cfg_data
);

  localparam int LW  = $clog2(PAYLOAD_BYTES + 1);
  localparam int AW  = $clog2(PAYLOAD_BYTES);
  localparam int RW  = (LW > 14) ? LW : 14;
  localparam int YW  = RW + 14;
  localparam int NDW = YW + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_MUL1, S_MUL2, S_CHK, S_RDY, S_RDU, S_RDV, S_CAP, S_COL
  } state_t;

  state_t state_r;

  logic [5:0]  color_format_r;
  logic        output_abgr_r;
  logic [12:0] frame_width_r;
  logic [12:0] frame_height_r;
  logic [13:0] luma_stride_r;
  logic [13:0] slice_height_r;
  logic [LW-1:0] len_r;

  logic [11:0]   col_r, row_r;
  logic [RW-1:0] rows_r, uvrows_r;
  logic [13:0]   uvstride_r;
  logic [YW-1:0] ysize_r, uvsize_r;
  logic [25:0]   luma_off_r, crow_off_r;
  logic [LW-1:0] luma_addr_r, ubase_r, uaddr_r, vaddr_r;
  logic [7:0]    y_r, u_r;
  logic          out_valid_r;
  logic [31:0]   out_word_r;
  logic [1:0]    out_status_r;

  logic          accept, wr_fire, planar, semi;
  logic [12:0]   width_eff, height_eff, wlim;
  logic [13:0]   stride_eff, slice_eff;
  logic [15:0]   divisor;
  logic [LW:0]   quotient;
  logic          div_done;
  logic [RW-1:0] guessed;
  logic [NDW-1:0] need;
  logic          short_err, outside;
  logic          ram_en;
  logic [LW-1:0] ram_addr;
  logic [7:0]    ram_rdata;
  logic          col_valid;
  logic [31:0]   col_word;
  logic [11:0]   uv_off;

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign wr_fire = accept && (in_operation == OP_APPEND) && (len_r < LW'(PAYLOAD_BYTES));

  assign planar = (color_format_r == FMT_PLANAR_A) || (color_format_r == FMT_PLANAR_B);
  assign semi   = (color_format_r == FMT_SEMI_A) || (color_format_r == FMT_SEMI_B);

  always_comb begin
    if (frame_width_r == 13'd0) width_eff = 13'd1;
    else if (32'(frame_width_r) > MAX_DIMENSION) width_eff = 13'(MAX_DIMENSION);
    else width_eff = frame_width_r;
    if (frame_height_r == 13'd0) height_eff = 13'd1;
    else if (32'(frame_height_r) > MAX_DIMENSION) height_eff = 13'(MAX_DIMENSION);
    else height_eff = frame_height_r;
  end

  assign stride_eff = (luma_stride_r < {1'b0, width_eff}) ? {1'b0, width_eff} : luma_stride_r;
  assign slice_eff  = (slice_height_r < {1'b0, height_eff}) ? {1'b0, height_eff}
                                                            : slice_height_r;
  assign wlim       = planar ? width_eff : {width_eff[12:1], 1'b0};
  assign divisor    = {2'b00, stride_eff} + {1'b0, stride_eff, 1'b0};
  assign guessed    = RW'(quotient[LW-1:0]);

  assign need      = NDW'(ysize_r) + (planar ? {1'b0, uvsize_r, 1'b0} : NDW'(uvsize_r));
  assign short_err = (uvstride_r == 14'd0) || (NDW'(len_r) < need);
  assign outside   = ({1'b0, col_r} >= wlim) || ({1'b0, row_r} >= height_eff);
  assign uv_off    = planar ? {1'b0, col_r[11:1]} : {col_r[11:1], 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_format_r <= FMT_PLANAR_A;
      output_abgr_r  <= 1'b0;
      frame_width_r  <= 13'd1;
      frame_height_r <= 13'd1;
      luma_stride_r  <= 14'd1;
      slice_height_r <= 14'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLOR_FORMAT: color_format_r <= cfg_data[5:0];
        CFG_OUTPUT_ABGR:  output_abgr_r  <= cfg_data[0];
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data[12:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data[12:0];
        CFG_LUMA_STRIDE:  luma_stride_r  <= cfg_data;
        CFG_SLICE_HEIGHT: slice_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (accept && (in_operation == OP_CLEAR)) begin
      len_r <= '0;
    end else if (wr_fire) begin
      len_r <= len_r + LW'(1);
    end
  end

  always_comb begin
    ram_en   = wr_fire;
    ram_addr = len_r;
    case (state_r)
      S_RDY: begin
        ram_en   = 1'b1;
        ram_addr = luma_addr_r;
      end
      S_RDU: begin
        ram_en   = 1'b1;
        ram_addr = uaddr_r;
      end
      S_RDV: begin
        ram_en   = 1'b1;
        ram_addr = vaddr_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept && (in_operation == OP_CONVERT)) begin
            col_r   <= in_pixel_column;
            row_r   <= in_pixel_row;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            rows_r  <= (guessed > RW'(slice_eff)) ? guessed : RW'(slice_eff);
            state_r <= S_MUL1;
          end
        end
        S_MUL1: begin
          ysize_r    <= YW'(stride_eff) * YW'(rows_r);
          uvrows_r   <= RW'(({1'b0, rows_r} + (RW + 1)'(1)) >> 1);
          uvstride_r <= planar ? {1'b0, stride_eff[13:1]} : stride_eff;
          state_r    <= S_MUL2;
        end
        S_MUL2: begin
          uvsize_r   <= YW'(uvstride_r) * YW'(uvrows_r);
          luma_off_r <= 26'(row_r) * 26'(stride_eff);
          crow_off_r <= 26'(row_r[11:1]) * 26'(uvstride_r);
          state_r    <= S_CHK;
        end
        S_CHK: begin
          luma_addr_r <= LW'({1'b0, luma_off_r} + 27'(col_r));
          ubase_r     <= LW'(ysize_r) + LW'(crow_off_r);
          if (!planar && !semi) begin
            out_valid_r  <= 1'b1;
            out_status_r <= STAT_UNSUP;
            out_word_r   <= 32'd0;
            state_r      <= S_IDLE;
          end else if (short_err) begin
            out_valid_r  <= 1'b1;
            out_status_r <= STAT_SHORT;
            out_word_r   <= 32'd0;
            state_r      <= S_IDLE;
          end else if (outside) begin
            out_valid_r  <= 1'b1;
            out_status_r <= STAT_OUTSIDE;
            out_word_r   <= 32'd0;
            state_r      <= S_IDLE;
          end else begin
            state_r <= S_RDY;
          end
        end
        S_RDY: begin
          uaddr_r <= ubase_r + LW'(uv_off);
          state_r <= S_RDU;
        end
        S_RDU: begin
          y_r     <= ram_rdata;
          vaddr_r <= uaddr_r + (planar ? LW'(uvsize_r) : LW'(1));
          state_r <= S_RDV;
        end
        S_RDV: begin
          u_r     <= ram_rdata;
          state_r <= S_CAP;
        end
        S_CAP: begin
          state_r <= S_COL;
        end
        S_COL: begin
          if (col_valid) begin
            out_valid_r  <= 1'b1;
            out_status_r <= STAT_OK;
            out_word_r   <= col_word;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  yfc_divider #(
    .NW(LW + 1),
    .DW(16)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start_i   (accept && (in_operation == OP_CONVERT)),
    .dividend_i({len_r, 1'b0}),
    .divisor_i (divisor),
    .done_o    (div_done),
    .quotient_o(quotient)
  );

  yfc_payload_ram #(
    .DEPTH(PAYLOAD_BYTES),
    .AW   (AW),
    .LW   (LW)
  ) u_ram (
    .clk  (clk),
    .en   (ram_en),
    .we   (wr_fire),
    .addr (ram_addr),
    .wdata(in_payload_byte),
    .rdata(ram_rdata)
  );

  yfc_colour u_colour (
    .clk    (clk),
    .rst_n  (rst_n),
    .valid_i(state_r == S_CAP),
    .abgr_i (output_abgr_r),
    .y_i    (y_r),
    .u_i    (u_r),
    .v_i    (ram_rdata),
    .valid_o(col_valid),
    .word_o (col_word)
  );

  assign out_valid      = out_valid_r;
  assign out_pixel_word = out_word_r;
  assign out_status     = out_status_r;

endmodule

// File: design/yfc_checker.sv
// ----------------------------------------------------------------------------
// yfc_checker
// Port-level checks for the frame converter, bound to the top level.
// ----------------------------------------------------------------------------
module yfc_checker
  import yfc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_operation,
  input logic        out_valid,
  input logic [31:0] out_pixel_word,
  input logic [1:0]  out_status
);

  a_convert_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_operation == OP_CONVERT) |=> busy)
    else $error("convert transaction did not raise busy");

  a_fill_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_operation != OP_CONVERT) |=> !busy && !out_valid)
    else $error("clear or append transaction caused busy or a result");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) && !busy)
    else $error("result strobe without a convert in flight");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_OK) |-> (out_pixel_word == 32'd0))
    else $error("error result carries a non-zero pixel word");

  a_ok_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_OK) |-> (out_pixel_word[31:24] == ALPHA_OPAQUE))
    else $error("pixel word not opaque");

endmodule

bind yuv420_frame_to_argb_converter_unit yfc_checker u_yfc_checker (.*);

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the YUV 4:2:0 frame to ARGB converter. A directed
// table covers reset values, colour code and position errors, the odd-width
// semiplanar edge and the read one byte past the payload. Random frames
// follow: clear, append a payload sized from the configured layout, then
// convert pixels, with noise transactions and random sender gaps. Each
// result is checked against a local model of the layout and BT.601 transform.
// ----------------------------------------------------------------------------
module testbench
  import yfc_pkg::*;
();

  localparam int PAYLOAD_BYTES   = 4194304;
  localparam int MAX_DIMENSION   = 4096;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int RANDOM_ITEMS    = 900;
  localparam int PREFILL_BYTES   = 300;
  localparam int MAX_FRAME_BYTES = 240;
  localparam int PLAN_ROWS       = 41;

  typedef enum logic {ROW_ITEM, ROW_REG} plan_kind_t;

  typedef struct packed {
    plan_kind_t  kind;
    logic [2:0]  reg_idx;
    logic [1:0]  op;
    logic [13:0] value;
    logic [11:0] col;
    logic [11:0] row;
    logic        fixed;
    logic [1:0]  fixed_status;
  } plan_row_t;

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  status;
  } pixel_result_t;

  typedef struct {
    bit     planar;
    longint width;
    longint height;
    longint stride;
    longint ysize;
    longint uvstride;
    longint uvsize;
    longint need;
  } frame_geom_t;

  // Item rows carry CFG_COLOR_FORMAT and register rows OP_CLEAR as fillers.
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{ROW_ITEM, CFG_COLOR_FORMAT, OP_CONVERT, 14'h0, 12'h0, 12'h0, 1'b1, STAT_SHORT},
    '{ROW_ITEM, CFG_COLOR_FORMAT, OP_UNUSED, 14'hff, 12'hfff, 12'hfff, 1'b0, STAT_OK},
    '{ROW_REG, CFG_COLOR_FORMAT, OP_CLEAR, 14'd0, 12'h0, 12'h0, 1'b0, STAT_OK},
    '{ROW_ITEM, CFG_COLOR_FORMAT, OP_CONVERT, 14'h0, 12'hfff, 12'hfff, 1'b1, STAT_UNSUP},
    '{ROW_REG, CFG_COLOR_FORMAT, OP_CLEAR, 14'd63, 12'h0, 12'h0, 1'b0, STAT_OK},
    '{ROW_ITEM, CFG_COLOR_FORMAT, OP_CONVERT, 14'h0, 12'h0, 12'h0, 1'b1, STAT_UNSUP},
    '{ROW_REG, CFG_COLOR_FORMAT, OP_CLEAR, 14'(FMT_PLANAR_A), 12'h0, 12'h0, 1'b0, STAT_OK},
    '{ROW_REG, CFG_FRAME_WIDTH, OP_CLEAR, 14'd2, 12'h0, 12'h0, 1'b0, STAT_OK},
    '{ROW_REG, CFG_FRAME_HEIGHT, OP_CLEAR, 14'd2, 12'h0, 12'h0, 1'b0, STAT_OK},
    '{ROW_REG, CFG_LUMA_STRIDE, OP_CLEAR, 14'd2, 12'h0, 12'h0, 1'b0, STAT_OK},
    '{ROW_REG, CFG_SLICE_HEIGHT, OP_CLEAR, 14'd2, 12'h0, 12'h0, 1'b0, STAT_OK},
    '{ROW_ITEM, CFG_COLOR_FORMAT, OP_APPEND, 14'hff, 12'h0, 12'h0, 1'b0, STAT_OK},
    '{ROW_ITEM, CFG_COLOR_FORMAT, OP_APPEND, 14'h00, 12'h0, 12'h0, 1'b0, STAT_OK},
    '{ROW_ITEM, CFG_COLOR_FORMAT, OP_APPEND, 14'h10, 12'h0, 12'h0, 1'b0, STAT_OK},
    '{ROW_ITEM, CFG_COLOR_FORMAT, OP_APPEND, 14'heb, 12'h0, 12'h0, 1'b0, STAT_OK},
    '{ROW_ITEM, CFG_COLOR_FORMAT, OP_APPEND, 14'h00, 12'h0, 12'h0, 1'b0, STAT_OK},
    '{ROW_ITEM, CFG_COLOR_FORMAT, OP_APPEND, 14'hff, 12'h0, 12'h0, 1'b0, STAT_OK},
    '{ROW_ITEM, CFG_COLOR_FORMAT, OP_CONVERT, 14'h0, 12'd1, 12'd1, 1'b0, STAT_OK},
    '{ROW_ITEM, CFG_COLOR_FORMAT, OP_CONVERT, 14'h0, 12'd0, 12'd0, 1'b0, STAT_OK},
    '{ROW_ITEM, CFG_COLOR_FORMAT, OP_CONVERT, 14'h0, 12'd2, 12'd0, 1'b1, STAT_OUTSIDE},
    '{ROW_ITEM, CFG_COLOR_FORMAT, OP_CONVERT, 14'h0, 12'd0, 12'hfff, 1'b1, STAT_OUTSIDE},
    '{ROW_REG, CFG_OUTPUT_ABGR, OP_CLEAR, 14'd1, 12'h0, 12'h0, 1'b0, STAT_OK},
    '{ROW_ITEM, CFG_COLOR_FORMAT, OP_CONVERT, 14'h0, 12'd0, 12'd1, 1'b0, STAT_OK},
    '{ROW_REG, CFG_COLOR_FORMAT, OP_CLEAR, 14'(FMT_SEMI_B), 12'h0, 12'h0, 1'b0, STAT_OK},
    '{ROW_REG, CFG_FRAME_WIDTH, OP_CLEAR, 14'd3, 12'h0, 12'h0, 1'b0, STAT_OK},
    '{ROW_REG, CFG_FRAME_HEIGHT, OP_CLEAR, 14'd1, 12'h0, 12'h0, 1'b0, STAT_OK},
    '{ROW_REG, CFG_LUMA_STRIDE, OP_CLEAR, 14'd3, 12'h0, 12'h0, 1'b0, STAT_OK},
    '{ROW_REG, CFG_SLICE_HEIGHT, OP_CLEAR, 14'd1, 12'h0, 12'h0, 1'b0, STAT_OK},
    '{ROW_ITEM, CFG_COLOR_FORMAT, OP_CONVERT, 14'h0, 12'd2, 12'd0, 1'b1, STAT_OUTSIDE},
    '{ROW_ITEM, CFG_COLOR_FORMAT, OP_CONVERT, 14'h0, 12'd1, 12'd0, 1'b0, STAT_OK},
    '{ROW_REG, CFG_COLOR_FORMAT, OP_CLEAR, 14'(FMT_PLANAR_B), 12'h0, 12'h0, 1'b0, STAT_OK},
    '{ROW_ITEM, CFG_COLOR_FORMAT, OP_CLEAR, 14'h0, 12'h0, 12'h0, 1'b0, STAT_OK},
    '{ROW_ITEM, CFG_COLOR_FORMAT, OP_CONVERT, 14'h0, 12'd0, 12'd0, 1'b1, STAT_SHORT},
    '{ROW_ITEM, CFG_COLOR_FORMAT, OP_APPEND, 14'h80, 12'h0, 12'h0, 1'b0, STAT_OK},
    '{ROW_ITEM, CFG_COLOR_FORMAT, OP_APPEND, 14'h80, 12'h0, 12'h0, 1'b0, STAT_OK},
    '{ROW_ITEM, CFG_COLOR_FORMAT, OP_APPEND, 14'h80, 12'h0, 12'h0, 1'b0, STAT_OK},
    '{ROW_ITEM, CFG_COLOR_FORMAT, OP_APPEND, 14'h40, 12'h0, 12'h0, 1'b0, STAT_OK},
    '{ROW_ITEM, CFG_COLOR_FORMAT, OP_APPEND, 14'hc0, 12'h0, 12'h0, 1'b0, STAT_OK},
    // odd stride, last column: V sample sits one byte past the payload
    '{ROW_ITEM, CFG_COLOR_FORMAT, OP_CONVERT, 14'h0, 12'd2, 12'd0, 1'b0, STAT_OK},
    '{ROW_REG, CFG_COLOR_FORMAT, OP_CLEAR, 14'(FMT_SEMI_A), 12'h0, 12'h0, 1'b0, STAT_OK},
    '{ROW_ITEM, CFG_COLOR_FORMAT, OP_CONVERT, 14'h0, 12'd0, 12'd0, 1'b1, STAT_SHORT}
  };

  localparam logic [5:0] LAYOUTS [4] = '{FMT_PLANAR_A, FMT_PLANAR_B, FMT_SEMI_A, FMT_SEMI_B};

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_operation;
  logic [7:0]  in_payload_byte;
  logic [11:0] in_pixel_column;
  logic [11:0] in_pixel_row;
  logic        out_valid;
  logic [31:0] out_pixel_word;
  logic [1:0]  out_status;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [13:0] cfg_data;

  pixel_result_t expected_pixels [$];
  byte unsigned  payload_shadow [int];
  int unsigned   payload_len;
  logic [5:0]    reg_format;
  logic          reg_abgr;
  logic [12:0]   reg_width;
  logic [12:0]   reg_height;
  logic [13:0]   reg_stride;
  logic [13:0]   reg_slice;
  int            errors;
  int            idle_cycles;
  int            items_sent;
  bit            zero_gaps;

  yuv420_frame_to_argb_converter_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_payload_byte (in_payload_byte),
    .in_pixel_column (in_pixel_column),
    .in_pixel_row    (in_pixel_row),
    .out_valid       (out_valid),
    .out_pixel_word  (out_pixel_word),
    .out_status      (out_status),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic frame_geom_t frame_geometry();
    frame_geom_t g;
    longint slice;
    longint rows;
    longint guessed;
    g.planar = (reg_format == FMT_PLANAR_A) || (reg_format == FMT_PLANAR_B);
    g.width = (reg_width == 0) ? 1 : reg_width;
    if (g.width > MAX_DIMENSION) g.width = MAX_DIMENSION;
    g.height = (reg_height == 0) ? 1 : reg_height;
    if (g.height > MAX_DIMENSION) g.height = MAX_DIMENSION;
    g.stride = (reg_stride < g.width) ? g.width : reg_stride;
    slice = (reg_slice < g.height) ? g.height : reg_slice;
    guessed = (longint'(payload_len) * 2) / (g.stride * 3);
    rows = (guessed > slice) ? guessed : slice;
    g.ysize = g.stride * rows;
    g.uvstride = g.planar ? g.stride / 2 : g.stride;
    g.uvsize = g.uvstride * ((rows + 1) / 2);
    g.need = g.ysize + g.uvsize * (g.planar ? 2 : 1);
    return g;
  endfunction

  function automatic int stored_byte(longint addr);
    if (addr >= PAYLOAD_BYTES || !payload_shadow.exists(int'(addr))) return 0;
    return payload_shadow[int'(addr)];
  endfunction

  function automatic logic [7:0] clamp_channel(int sum);
    if (sum < 0) return 8'd0;
    if ((sum >>> 8) > 255) return 8'hff;
    return 8'(sum >>> 8);
  endfunction

  function automatic pixel_result_t predict_pixel(logic [11:0] col, logic [11:0] row);
    pixel_result_t res;
    frame_geom_t   g;
    longint        w;
    longint        uaddr;
    longint        vaddr;
    int            c;
    int            d;
    int            e;
    logic [7:0]    red;
    logic [7:0]    green;
    logic [7:0]    blue;
    res.word = 32'h0;
    res.status = STAT_OK;
    if (reg_format != FMT_PLANAR_A && reg_format != FMT_PLANAR_B &&
        reg_format != FMT_SEMI_A && reg_format != FMT_SEMI_B) begin
      res.status = STAT_UNSUP;
      return res;
    end
    g = frame_geometry();
    if (g.uvstride == 0 || payload_len < g.need) begin
      res.status = STAT_SHORT;
      return res;
    end
    w = g.planar ? g.width : (g.width & ~longint'(1));
    if (longint'(col) >= w || longint'(row) >= g.height) begin
      res.status = STAT_OUTSIDE;
      return res;
    end
    uaddr = g.ysize + longint'(row / 2) * g.uvstride + longint'(col / 2) * (g.planar ? 1 : 2);
    vaddr = uaddr + (g.planar ? g.uvsize : 1);
    c = stored_byte(longint'(row) * g.stride + longint'(col)) - 16;
    if (c < 0) c = 0;
    d = stored_byte(uaddr) - 128;
    e = stored_byte(vaddr) - 128;
    red   = clamp_channel(298 * c + 409 * e + 128);
    green = clamp_channel(298 * c - 100 * d - 208 * e + 128);
    blue  = clamp_channel(298 * c + 516 * d + 128);
    res.word = reg_abgr ? {ALPHA_OPAQUE, blue, green, red} : {ALPHA_OPAQUE, red, green, blue};
    return res;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [13:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_COLOR_FORMAT: reg_format = value[5:0];
      CFG_OUTPUT_ABGR:  reg_abgr = value[0];
      CFG_FRAME_WIDTH:  reg_width = value[12:0];
      CFG_FRAME_HEIGHT: reg_height = value[12:0];
      CFG_LUMA_STRIDE:  reg_stride = value;
      CFG_SLICE_HEIGHT: reg_slice = value;
      default: ;
    endcase
  endtask

  task automatic push_item(logic [1:0] op, logic [7:0] data, logic [11:0] col,
                           logic [11:0] row, bit fixed = 1'b0,
                           logic [1:0] fixed_status = STAT_OK);
    int gap;
    pixel_result_t res;
    gap = zero_gaps ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_operation <= op;
    in_payload_byte <= data;
    in_pixel_column <= col;
    in_pixel_row <= row;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op != OP_UNUSED) items_sent++;
    case (op)
      OP_CLEAR: payload_len = 0;
      OP_APPEND: begin
        if (payload_len < PAYLOAD_BYTES) begin
          payload_shadow[int'(payload_len)] = data;
          payload_len++;
        end
      end
      OP_CONVERT: begin
        if (fixed) begin
          res.word = 32'h0;
          res.status = fixed_status;
        end else begin
          res = predict_pixel(col, row);
        end
        expected_pixels.push_back(res);
      end
      default: ;
    endcase
  endtask

  // idle point for register writes: no result owed and no transaction in flight
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (expected_pixels.size() != 0 || busy) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  always @(posedge clk) begin
    pixel_result_t want;
    if (!rst_n) begin
      idle_cycles = 0;
    end else begin
      if ((start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
      if (out_valid) begin
        if (expected_pixels.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, got word %h status %0d",
                   $time, out_pixel_word, out_status);
        end else begin
          want = expected_pixels.pop_front();
          if (want.word !== out_pixel_word) begin
            errors++;
            $display("%0t: pixel word: expected %h, got %h", $time, want.word, out_pixel_word);
          end
          if (want.status !== out_status) begin
            errors++;
            $display("%0t: status: expected %0d, got %0d", $time, want.status, out_status);
          end
        end
      end
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    frame_geom_t g;
    logic [13:0] cfg_vals [6];
    int          phase;
    int          w;
    int          h;
    int          len_target;
    logic [11:0] col;
    logic [11:0] row;
    rst_n = 1'b0;
    start = 1'b0;
    in_operation = OP_CLEAR;
    in_payload_byte = 8'h0;
    in_pixel_column = 12'h0;
    in_pixel_row = 12'h0;
    cfg_we = 1'b0;
    cfg_index = CFG_COLOR_FORMAT;
    cfg_data = 14'h0;
    reg_format = FMT_PLANAR_A;
    reg_abgr = 1'b0;
    reg_width = 13'd1;
    reg_height = 13'd1;
    reg_stride = 14'd1;
    reg_slice = 14'd1;
    payload_len = 0;
    items_sent = 0;
    zero_gaps = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (PLAN[i].kind == ROW_REG) begin
        settle();
        write_reg(PLAN[i].reg_idx, PLAN[i].value);
      end else begin
        push_item(PLAN[i].op, PLAN[i].value[7:0], PLAN[i].col, PLAN[i].row,
                  PLAN[i].fixed, PLAN[i].fixed_status);
      end
    end

    // fill the low memory once so later frames never read unwritten bytes
    items_sent = 0;
    zero_gaps = 1'b1;
    repeat (PREFILL_BYTES) push_item(OP_APPEND, 8'($urandom), 12'($urandom), 12'($urandom));

    for (phase = 0; items_sent < RANDOM_ITEMS; phase++) begin
      settle();
      case (phase)
        0: begin
          cfg_vals[CFG_COLOR_FORMAT] = 14'(FMT_PLANAR_A);
          cfg_vals[CFG_OUTPUT_ABGR]  = 14'h3fff;
          cfg_vals[CFG_FRAME_WIDTH]  = 14'h3fff;
          cfg_vals[CFG_FRAME_HEIGHT] = 14'h3fff;
          cfg_vals[CFG_LUMA_STRIDE]  = 14'h3fff;
          cfg_vals[CFG_SLICE_HEIGHT] = 14'h3fff;
        end
        1: begin
          cfg_vals[CFG_COLOR_FORMAT] = {8'hff, FMT_SEMI_B};
          cfg_vals[CFG_OUTPUT_ABGR]  = 14'h0;
          cfg_vals[CFG_FRAME_WIDTH]  = 14'h0;
          cfg_vals[CFG_FRAME_HEIGHT] = 14'h0;
          cfg_vals[CFG_LUMA_STRIDE]  = 14'h0;
          cfg_vals[CFG_SLICE_HEIGHT] = 14'h0;
        end
        2: begin
          cfg_vals[CFG_COLOR_FORMAT] = 14'(FMT_SEMI_A);
          cfg_vals[CFG_OUTPUT_ABGR]  = 14'h1;
          cfg_vals[CFG_FRAME_WIDTH]  = 14'd4096;
          cfg_vals[CFG_FRAME_HEIGHT] = 14'd4096;
          cfg_vals[CFG_LUMA_STRIDE]  = 14'd8192;
          cfg_vals[CFG_SLICE_HEIGHT] = 14'd8192;
        end
        default: begin
          w = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 6);
          h = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 6);
          cfg_vals[CFG_COLOR_FORMAT] = {8'($urandom), ($urandom_range(0, 9) == 0) ?
                                        6'($urandom) : LAYOUTS[$urandom_range(0, 3)]};
          cfg_vals[CFG_OUTPUT_ABGR]  = 14'($urandom);
          cfg_vals[CFG_FRAME_WIDTH]  = {1'($urandom), 13'(w)};
          cfg_vals[CFG_FRAME_HEIGHT] = {1'($urandom), 13'(h)};
          cfg_vals[CFG_LUMA_STRIDE]  = ($urandom_range(0, 7) == 0) ?
                                       14'($urandom_range(0, w)) : 14'(w + $urandom_range(0, 3));
          cfg_vals[CFG_SLICE_HEIGHT] = ($urandom_range(0, 7) == 0) ?
                                       14'h0 : 14'(h + $urandom_range(0, 2));
        end
      endcase
      for (int k = 0; k < 6; k++) write_reg(3'(k), cfg_vals[k]);
      zero_gaps = ($urandom_range(0, 3) == 0);

      repeat ($urandom_range(1, 3)) begin
        push_item(OP_CLEAR, 8'($urandom), 12'($urandom), 12'($urandom));
        g = frame_geometry();
        if (g.need > MAX_FRAME_BYTES) begin
          len_target = $urandom_range(0, 40);
        end else begin
          len_target = int'(g.need);
          case ($urandom_range(0, 9))
            0: len_target = len_target - 1;
            1: len_target = len_target + int'(g.stride) * 3 * $urandom_range(1, 2);
            default: ;
          endcase
          if (len_target < 0 || len_target > MAX_FRAME_BYTES) len_target = $urandom_range(0, 40);
        end
        repeat (len_target) push_item(OP_APPEND, 8'($urandom), 12'($urandom), 12'($urandom));
        g = frame_geometry();
        repeat ($urandom_range(3, 10)) begin
          if ($urandom_range(0, 7) == 0) begin
            col = 12'($urandom);
            row = 12'($urandom);
          end else begin
            col = 12'($urandom_range(0, int'(g.width)));
            row = 12'($urandom_range(0, int'(g.height)));
          end
          push_item(OP_CONVERT, 8'($urandom), col, row);
          case ($urandom_range(0, 11))
            0: push_item(OP_UNUSED, 8'($urandom), 12'($urandom), 12'($urandom));
            1: push_item(OP_APPEND, 8'($urandom), 12'($urandom), 12'($urandom));
            default: ;
          endcase
        end
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
